// ===== rtl/core/mmt_pkg.sv =====
// Shared types and constants of the multiset mode tracker.
`default_nettype none

package mmt_pkg;

	localparam int COLORS_DEF    = 1024;
	localparam int MAX_COUNT_DEF = 1024;
	localparam int COLOR_W       = 10;
	localparam int FIELD_W       = 11;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [COLOR_W-1:0] color;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] max_count;
		logic [FIELD_W-1:0] colors_at_max;
		logic               rejected;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mmt_stream_if.sv =====
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none

interface mmt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/multiset_mode_tracker_unit.sv =====
// Multiset mode tracker: per-color counts, count histogram and running mode.
//
// Each transfer on item inserts or removes one occurrence of a color; one
// result per item reports the highest count and how many colors hold it,
// with rejected set when the update was ignored. Items are taken one per
// cycle while item.ready is high. The color count table is read at the item
// transfer and checked in the first stage, the histogram (split into even
// and odd count banks so both touched entries are read and written in the
// same cycle) is updated in the second, and the result is queued in a
// four-entry output buffer; result.valid is high while the buffer holds a
// result. item.ready drops while the buffer and the two stages together
// hold four results, so a stalled receiver stops the input after four
// items. After reset the block runs a clearing pass over the color count
// table and both histogram banks during which item.ready stays low.
`default_nettype none

module multiset_mode_tracker_unit #(
	parameter int COLORS    = mmt_pkg::COLORS_DEF,
	parameter int MAX_COUNT = mmt_pkg::MAX_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mmt_stream_if.sink   item,
	mmt_stream_if.source result
);
	import mmt_pkg::*;

	localparam int IDX_W      = $clog2(COLORS);
	localparam int CNT_W      = $clog2(MAX_COUNT + 1);
	localparam int HIST_W     = $clog2(COLORS + 1);
	localparam int BANK_DEPTH = MAX_COUNT / 2 + 1;
	localparam int BA_W       = $clog2(BANK_DEPTH);
	localparam int CLR_LEN    = (COLORS > BANK_DEPTH) ? COLORS : BANK_DEPTH;
	localparam int CLR_W      = $clog2(CLR_LEN);
	localparam int FIFO_DEPTH = 4;
	localparam int FP_W       = $clog2(FIFO_DEPTH);
	localparam int FC_W       = $clog2(FIFO_DEPTH + 1) + 1;

	// clearing pass
	logic             clearing_q;
	logic [CLR_W-1:0] clr_q;

	// memories
	logic [CNT_W-1:0]  cc_mem_q [COLORS];
	logic [HIST_W-1:0] ev_mem_q [BANK_DEPTH];
	logic [HIST_W-1:0] od_mem_q [BANK_DEPTH];
	logic [CNT_W-1:0]  cc_rd_q;
	logic [HIST_W-1:0] ev_rd_q;
	logic [HIST_W-1:0] od_rd_q;

	// stage 1
	logic             v_s1;
	cmd_t             cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             inr_s1;

	// stage 2
	logic             v_s2;
	logic             upd_s2;
	logic             rej_s2;
	cmd_t             cmd_s2;
	logic [CNT_W-1:0] old_s2;
	logic [CNT_W-1:0] now_s2;
	logic [BA_W-1:0]  ev_ra_s2;
	logic [BA_W-1:0]  od_ra_s2;

	// last-write forwarding
	logic              cw_vld_q;
	logic [IDX_W-1:0]  cw_idx_q;
	logic [CNT_W-1:0]  cw_cnt_q;
	logic              hw_vld_q;
	logic [BA_W-1:0]   ew_addr_q;
	logic [HIST_W-1:0] ew_dat_q;
	logic [BA_W-1:0]   ow_addr_q;
	logic [HIST_W-1:0] ow_dat_q;

	// mode state
	logic [CNT_W-1:0]  best_q;
	logic [HIST_W-1:0] at_q;

	// output buffer
	result_t          fifo_q [FIFO_DEPTH];
	logic [FP_W-1:0]  wr_ptr_q;
	logic [FP_W-1:0]  rd_ptr_q;
	logic [FC_W-1:0]  fifo_cnt_q;

	logic              acc;
	logic              pop;
	logic [FC_W-1:0]   occ;
	logic [CNT_W-1:0]  old_s1;
	logic [CNT_W-1:0]  now_s1;
	logic              rej_s1;
	logic              upd_s1;
	logic [BA_W-1:0]   old_ba;
	logic [BA_W-1:0]   now_ba;
	logic [BA_W-1:0]   ev_ra;
	logic [BA_W-1:0]   od_ra;
	logic              cc_we;
	logic [IDX_W-1:0]  cc_wa;
	logic [CNT_W-1:0]  cc_wd;
	logic [HIST_W-1:0] h_ev;
	logic [HIST_W-1:0] h_od;
	logic [HIST_W-1:0] h_old;
	logic [HIST_W-1:0] h_now;
	logic [HIST_W-1:0] new_old;
	logic [HIST_W-1:0] new_now;
	logic              ev_we;
	logic [BA_W-1:0]   ev_wa;
	logic [HIST_W-1:0] ev_wd;
	logic              od_we;
	logic [BA_W-1:0]   od_wa;
	logic [HIST_W-1:0] od_wd;
	logic [CNT_W-1:0]  best_n;
	logic [HIST_W-1:0] at_n;
	result_t           res_s2;

	// accept while no clearing runs and the buffer has room for all in flight
	assign occ        = fifo_cnt_q + FC_W'(v_s1) + FC_W'(v_s2);
	assign item.ready = !clearing_q && (occ < FC_W'(FIFO_DEPTH));
	assign acc        = item.valid && item.ready;
	assign pop        = result.valid && result.ready;

	// sweep all tables once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == CLR_W'(CLR_LEN - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// stage 1: old count with forwarding of the previous write
	always_comb begin
		old_s1 = (cw_vld_q && cw_idx_q == idx_s1) ? cw_cnt_q : cc_rd_q;
		now_s1 = (cmd_s1 == CMD_REMOVE) ? old_s1 - 1'b1 : old_s1 + 1'b1;
		if (!inr_s1) begin
			rej_s1 = 1'b1;
		end else if (cmd_s1 == CMD_REMOVE) begin
			rej_s1 = (old_s1 == '0);
		end else begin
			rej_s1 = (old_s1 == CNT_W'(MAX_COUNT));
		end
		upd_s1 = v_s1 && !rej_s1;
		old_ba = BA_W'(old_s1 >> 1);
		now_ba = BA_W'(now_s1 >> 1);
		ev_ra  = old_s1[0] ? now_ba : old_ba;
		od_ra  = old_s1[0] ? old_ba : now_ba;
	end

	// color count write port: clearing pass or stage 1 update
	always_comb begin
		if (clearing_q) begin
			cc_we = (32'(clr_q) < COLORS);
			cc_wa = IDX_W'(clr_q);
			cc_wd = '0;
		end else begin
			cc_we = upd_s1;
			cc_wa = idx_s1;
			cc_wd = now_s1;
		end
	end

	always_ff @(posedge clk) begin
		cc_rd_q <= cc_mem_q[IDX_W'(item.data.color)];
		if (cc_we) begin
			cc_mem_q[cc_wa] <= cc_wd;
		end
	end

	// stage 2: histogram entries with forwarding, then decrement old / increment new
	always_comb begin
		h_ev    = (hw_vld_q && ew_addr_q == ev_ra_s2) ? ew_dat_q : ev_rd_q;
		h_od    = (hw_vld_q && ow_addr_q == od_ra_s2) ? ow_dat_q : od_rd_q;
		h_old   = old_s2[0] ? h_od : h_ev;
		h_now   = old_s2[0] ? h_ev : h_od;
		new_old = h_old - 1'b1;
		new_now = h_now + 1'b1;
	end

	// histogram bank write ports
	always_comb begin
		if (clearing_q) begin
			ev_we = (32'(clr_q) < BANK_DEPTH);
			ev_wa = BA_W'(clr_q);
			ev_wd = (clr_q == '0) ? HIST_W'(COLORS) : '0;
			od_we = ev_we;
			od_wa = BA_W'(clr_q);
			od_wd = '0;
		end else begin
			ev_we = upd_s2;
			ev_wa = ev_ra_s2;
			ev_wd = old_s2[0] ? new_now : new_old;
			od_we = upd_s2;
			od_wa = od_ra_s2;
			od_wd = old_s2[0] ? new_old : new_now;
		end
	end

	always_ff @(posedge clk) begin
		ev_rd_q <= ev_mem_q[ev_ra];
		od_rd_q <= od_mem_q[od_ra];
		if (ev_we) begin
			ev_mem_q[ev_wa] <= ev_wd;
		end
		if (od_we) begin
			od_mem_q[od_wa] <= od_wd;
		end
	end

	// advance the mode and the number of colors at it
	always_comb begin
		best_n = best_q;
		at_n   = at_q;
		if (upd_s2) begin
			if (cmd_s2 == CMD_INSERT) begin
				if (now_s2 > best_q) begin
					best_n = now_s2;
					at_n   = HIST_W'(1);
				end else if (now_s2 == best_q) begin
					at_n = at_q + 1'b1;
				end
			end else if (old_s2 == best_q) begin
				if (at_q == HIST_W'(1)) begin
					best_n = now_s2;
					at_n   = new_now;
				end else begin
					at_n = at_q - 1'b1;
				end
			end
		end
		res_s2.max_count     = FIELD_W'(best_n);
		res_s2.colors_at_max = FIELD_W'(at_n);
		res_s2.rejected      = rej_s2;
	end

	// control registers of the pipeline, forwarding and mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			upd_s2   <= 1'b0;
			cw_vld_q <= 1'b0;
			hw_vld_q <= 1'b0;
			best_q   <= '0;
			at_q     <= HIST_W'(COLORS);
		end else begin
			v_s1     <= acc;
			v_s2     <= v_s1;
			upd_s2   <= upd_s1;
			cw_vld_q <= upd_s1;
			hw_vld_q <= upd_s2;
			best_q   <= best_n;
			at_q     <= at_n;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_s1    <= item.data.cmd;
		idx_s1    <= IDX_W'(item.data.color);
		inr_s1    <= (32'(item.data.color) < COLORS);
		rej_s2    <= rej_s1;
		cmd_s2    <= cmd_s1;
		old_s2    <= old_s1;
		now_s2    <= now_s1;
		ev_ra_s2  <= ev_ra;
		od_ra_s2  <= od_ra;
		cw_idx_q  <= idx_s1;
		cw_cnt_q  <= now_s1;
		ew_addr_q <= ev_ra_s2;
		ew_dat_q  <= ev_wd;
		ow_addr_q <= od_ra_s2;
		ow_dat_q  <= od_wd;
	end

	// output buffer: push every stage 2 result, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (v_s2) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + FC_W'(v_s2) - FC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			fifo_q[wr_ptr_q] <= res_s2;
		end
	end

	assign result.valid = (fifo_cnt_q != '0);
	assign result.data  = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/core/mmt_checker.sv =====
// Port-level checks of the multiset mode tracker, bound to the top level.
`default_nettype none

module mmt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             result_valid,
	input logic             result_ready,
	input mmt_pkg::result_t result_data
);
	import mmt_pkg::*;

	logic               xfer;
	logic               have_q;
	logic [FIELD_W-1:0] last_max_q;
	logic [FIELD_W-1:0] last_at_q;
	logic [FIELD_W-1:0] last_inc;

	assign xfer     = result_valid && result_ready;
	assign last_inc = last_max_q + 1'b1;

	// hold the previous result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			last_max_q <= '0;
			last_at_q  <= '0;
		end else if (xfer) begin
			have_q     <= 1'b1;
			last_max_q <= result_data.max_count;
			last_at_q  <= result_data.colors_at_max;
		end
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped before transfer");

	a_mode_populated: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.colors_at_max != '0)
		else $error("no colour reported at the mode");

	a_mode_step: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && have_q |-> (result_data.max_count == last_max_q ||
			result_data.max_count == last_inc ||
			result_data.max_count + 1'b1 == last_max_q))
		else $error("mode moved by more than one between results");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && have_q && result_data.rejected |->
			(result_data.max_count == last_max_q &&
			result_data.colors_at_max == last_at_q))
		else $error("rejected item changed the reported mode");

endmodule

bind multiset_mode_tracker_unit mmt_checker u_mmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

`default_nettype wire

// ===== tb/multiset_mode_tracker_unit_tb.sv =====
// Self-checking testbench for the multiset mode tracker: stimulus, stall patterns, report checks.
`timescale 1ns / 1ps

module multiset_mode_tracker_unit_tb;

	import mmt_pkg::*;

	localparam int N_COLORS     = COLORS_DEF;
	localparam int N_MAX        = MAX_COUNT_DEF;
	localparam int POOL_N       = 8;
	localparam int LIMIT_CYCLES = 800000;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 200;

	// Track color counts, the count histogram and the running mode; hold the reports due.
	class mode_ledger;
		logic [FIELD_W-1:0] color_count [N_COLORS];
		logic [FIELD_W-1:0] count_hist [N_MAX+1];
		logic [FIELD_W-1:0] best;
		result_t            due_reports [$];
		int                 errors;
		int                 compared;
		int                 refused;
		int                 updates;
		int                 peak;

		function new();
			foreach (color_count[i]) color_count[i] = '0;
			foreach (count_hist[i]) count_hist[i] = '0;
			count_hist[0] = FIELD_W'(N_COLORS);
			best = '0;
			errors = 0;
			compared = 0;
			refused = 0;
			updates = 0;
			peak = 0;
		endfunction

		// Apply one accepted update and queue the report it produces.
		function void record_update(item_t it);
			int      c;
			int      old;
			bit      rej;
			result_t want;
			c = int'(it.color);
			rej = 1'b0;
			updates++;
			if (c >= N_COLORS) begin
				rej = 1'b1;
			end else begin
				old = int'(color_count[c]);
				if (it.cmd == CMD_INSERT) begin
					if (old >= N_MAX) begin
						rej = 1'b1;
					end else begin
						count_hist[old] = count_hist[old] - 1'b1;
						count_hist[old+1] = count_hist[old+1] + 1'b1;
						color_count[c] = color_count[c] + 1'b1;
						if (int'(best) < old + 1)
							best = best + 1'b1;
					end
				end else begin
					if (old == 0) begin
						rej = 1'b1;
					end else begin
						count_hist[old] = count_hist[old] - 1'b1;
						count_hist[old-1] = count_hist[old-1] + 1'b1;
						color_count[c] = color_count[c] - 1'b1;
						// drop the mode only when its last holder moved down
						if (int'(best) == old && count_hist[old] == '0)
							best = best - 1'b1;
					end
				end
			end
			if (rej)
				refused++;
			if (int'(best) > peak)
				peak = int'(best);
			want.max_count = best;
			want.colors_at_max = count_hist[best];
			want.rejected = rej;
			due_reports = {due_reports, want};
		endfunction

		// Compare one report field by field with the oldest one due.
		function void check_report(result_t got);
			result_t want;
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t: report with none due: max_count=%0d colors_at_max=%0d rejected=%0d",
					$time, got.max_count, got.colors_at_max, got.rejected);
				return;
			end
			want = due_reports.pop_front();
			compared++;
			if (got.max_count !== want.max_count) begin
				errors++;
				$display("%0t: max_count mismatch: expected %0d, actual %0d",
					$time, want.max_count, got.max_count);
			end
			if (got.colors_at_max !== want.colors_at_max) begin
				errors++;
				$display("%0t: colors_at_max mismatch: expected %0d, actual %0d",
					$time, want.colors_at_max, got.colors_at_max);
			end
			if (got.rejected !== want.rejected) begin
				errors++;
				$display("%0t: rejected mismatch: expected %0d, actual %0d",
					$time, want.rejected, got.rejected);
			end
		endfunction

		function int outstanding();
			return due_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   no_idle;
	bit   hold_done;
	int   cycle_cnt;
	int   items_sent;

	logic [COLOR_W-1:0] pool [POOL_N];

	mode_ledger ledger = new();

	mmt_stream_if #(.T(item_t))   item_if ();
	mmt_stream_if #(.T(result_t)) result_if ();

	multiset_mode_tracker_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles, %0d reports still due",
				$time, cycle_cnt, ledger.outstanding());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Watch both channels: record accepted updates, check accepted reports
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_if.valid && item_if.ready)
				ledger.record_update(item_if.data);
			if (result_if.valid && result_if.ready)
				ledger.check_report(result_if.data);
		end
	end

	// Mostly short gaps, a few long ones, none during calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic item_t make_item(cmd_t cmd, int color);
		item_t it;
		it.cmd = cmd;
		it.color = COLOR_W'(color);
		return it;
	endfunction

	// Draw mostly from the small color pool so counts pile up and tie
	function automatic item_t pool_item(int remove_pct);
		item_t it;
		it.cmd = ($urandom_range(99) < remove_pct) ? CMD_REMOVE : CMD_INSERT;
		if ($urandom_range(99) < 85)
			it.color = pool[$urandom_range(POOL_N-1)];
		else
			it.color = COLOR_W'($urandom_range(N_COLORS-1));
		return it;
	endfunction

	function automatic void refill_pool();
		foreach (pool[i]) pool[i] = COLOR_W'($urandom_range(N_COLORS-1));
	endfunction

	// Offer one item until transferred, then idle for the given gap
	task automatic send_item(item_t it, int gap);
		item_if.valid <= 1'b1;
		item_if.data <= it;
		do @(posedge clk); while (!item_if.ready);
		items_sent++;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every due report has come back
	task automatic wait_drained();
		while (ledger.outstanding() != 0) @(posedge clk);
	endtask

	// Receiver: random stalls, calm stretches, one long hold-off
	initial begin
		int gap;
		result_if.ready <= 1'b0;
		hold_done = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!hold_done && ledger.compared >= HOLD_AFTER) begin
				hold_done = 1'b1;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				result_if.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					result_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				result_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Sender: directed updates, pooled random, count-limit pump, mode descent
	initial begin
		item_t dir_q [$];
		int    n;
		int    gap;
		int    pump_color;
		int    pump_n;

		cycle_cnt = 0;
		items_sent = 0;
		no_idle = 1'b0;
		arst_n <= 1'b0;
		item_if.valid <= 1'b0;
		item_if.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: edge colors, ties, removal from empty, return to empty set
		dir_q = {dir_q, make_item(CMD_REMOVE, 0)};
		dir_q = {dir_q, make_item(CMD_INSERT, 0)};
		dir_q = {dir_q, make_item(CMD_INSERT, N_COLORS-1)};
		dir_q = {dir_q, make_item(CMD_INSERT, 0)};
		dir_q = {dir_q, make_item(CMD_REMOVE, N_COLORS-1)};
		dir_q = {dir_q, make_item(CMD_REMOVE, N_COLORS-1)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 0)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 0)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 0)};
		dir_q = {dir_q, make_item(CMD_INSERT, 'h2AA)};
		dir_q = {dir_q, make_item(CMD_INSERT, 'h155)};
		dir_q = {dir_q, make_item(CMD_INSERT, 'h2AA)};
		dir_q = {dir_q, make_item(CMD_INSERT, 'h155)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 'h2AA)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 'h155)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 'h2AA)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 'h155)};
		dir_q = {dir_q, make_item(CMD_REMOVE, 'h155)};
		foreach (dir_q[i]) begin
			gap = pick_gap();
			if (i == dir_q.size() - 1)
				gap = gap + 1;
			send_item(dir_q[i], gap);
		end
		wait_drained();

		// Pooled random with noise; the long receiver hold-off lands here
		refill_pool();
		n = 500;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(3) == 0);
			if (i % 120 == 0)
				refill_pool();
			gap = pick_gap();
			if (i == n - 1)
				gap = gap + 1;
			send_item(pool_item(40), gap);
		end
		no_idle = 1'b0;
		wait_drained();

		// Pump one color to the count limit, then push past it
		pump_color = $urandom_range(N_COLORS-1);
		pump_n = N_MAX - int'(ledger.color_count[pump_color]) + 2;
		for (int i = 0; i < pump_n; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(1) == 0);
			gap = pick_gap();
			if (i == pump_n - 1)
				gap = gap + 1;
			send_item(make_item(CMD_INSERT, pump_color), gap);
		end
		no_idle = 1'b0;
		wait_drained();

		// Walk the mode down from the limit among pooled traffic
		refill_pool();
		n = 300;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				no_idle = ($urandom_range(3) == 0);
			gap = pick_gap();
			if (i == n - 1)
				gap = gap + 1;
			if ($urandom_range(1) == 0)
				send_item(make_item(CMD_REMOVE, pump_color), gap);
			else
				send_item(pool_item(50), gap);
		end
		no_idle = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		if (ledger.outstanding() != 0) begin
			ledger.errors += ledger.outstanding();
			$display("%0t: %0d reports never arrived", $time, ledger.outstanding());
		end
		$display("Run: %0d updates sent (%0d refused), %0d reports compared, peak mode %0d.",
			items_sent, ledger.refused, ledger.compared, ledger.peak);
		$display("Run: empty-set removals, count-limit inserts, ties, long output stall.");
		if (ledger.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mmt_pkg.sv
rtl/core/mmt_stream_if.sv
rtl/core/multiset_mode_tracker_unit.sv
rtl/core/mmt_checker.sv
tb/multiset_mode_tracker_unit_tb.sv
